[hw/rtl/smbus_master_transfer_sequencer_macros.svh]
// Assertion macros for the SMBus master transfer sequencer.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef SMBUS_MASTER_TRANSFER_SEQUENCER_MACROS_SVH
`define SMBUS_MASTER_TRANSFER_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define SMBMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("smbus sequencer: implication check failed");

// Next-cycle implication, checked outside reset.
`define SMBMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("smbus sequencer: next-cycle check failed");

`else

`define SMBMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SMBMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/smbms_pkg.sv]
// Types and codes for the SMBus master transfer sequencer.
// No dependencies; imported by smbus_master_transfer_sequencer.
`timescale 1ns / 1ps

package smbms_pkg;

	typedef enum logic {
		OP_START = 1'b0,
		OP_EVENT = 1'b1
	} operation_t;

	typedef enum logic [1:0] {
		BUS_START_SENT    = 2'd0,
		BUS_BYTE_SENT     = 2'd1,
		BUS_BYTE_RECEIVED = 2'd2,
		BUS_OTHER         = 2'd3
	} bus_status_t;

	typedef enum logic [1:0] {
		MODE_WRITE        = 2'd0,
		MODE_READ         = 2'd1,
		MODE_WRITE_WADDR  = 2'd2,
		MODE_RANDOM_READ  = 2'd3
	} transfer_mode_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TARGET_ADDRESS  = 3'd0,
		CFG_TRANSFER_MODE   = 3'd1,
		CFG_WORD_ADDRESS    = 3'd2,
		CFG_TRANSFER_LENGTH = 3'd3,
		CFG_ACK_POLL_ENABLE = 3'd4
	} cfg_index_t;

	// Sequencer state carried from one word to the next.
	typedef struct packed {
		logic       busy;
		logic       read_dir;
		logic       waddr_pend;
		logic       rstart_pend;
		logic       rand_read;
		logic [7:0] byte_count;
	} seq_state_t;

	// One result word.
	typedef struct packed {
		logic       start_accepted;
		logic       drive_start;
		logic       drive_stop;
		logic       load_valid;
		logic [7:0] load_byte;
		logic       ack_out;
		logic       store_valid;
		logic [7:0] read_data;
		logic [7:0] byte_index;
		logic       busy_res;
		logic       failed;
	} seq_result_t;

endpackage

[hw/rtl/smbus_master_transfer_sequencer.sv]
// SMBus master transfer sequencer: top level, input stage, step logic, result register.
// Depends on smbms_pkg and smbus_master_transfer_sequencer_macros.svh.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid / in_stall) carries one word per start request or
//   bus-status event. Output channel (out_valid / out_stall) returns exactly one
//   result word per input word, in order.
//   Configuration (wr_en / wr_index / wr_data) is to be written only while idle;
//   the block itself does not enforce this. An index past the register list is ignored.
// Pipeline
//   A word is held in the input register while the step logic resolves it against
//   the sequencer state; the result register loads from the step logic when it is
//   empty or being drained, and out_valid then rises. One word per cycle is sustained
//   while out_stall is low.
// Reset
//   arst_n clears both stage valids and the sequencer state (not busy, count
//   zero); registers take their defaults, ack polling enabled.
// Stall
//   While out_stall holds a pending result, the input register still takes one
//   word; after that in_stall rises until the result is taken.
//
`include "smbus_master_transfer_sequencer_macros.svh"

module smbus_master_transfer_sequencer
	import smbms_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	input  logic [1:0]             bus_status,
	input  logic                   ack_received,
	input  logic [7:0]             received_byte,
	input  logic [7:0]             write_data,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   start_accepted,
	output logic                   drive_start,
	output logic                   drive_stop,
	output logic                   load_valid,
	output logic [7:0]             load_byte,
	output logic                   ack_out,
	output logic                   store_valid,
	output logic [7:0]             read_data,
	output logic [7:0]             byte_index,
	output logic                   busy_res,
	output logic                   failed
);

	// configuration registers
	logic [6:0]     target_address_q;
	transfer_mode_t transfer_mode_q;
	logic [7:0]     word_address_q;
	logic [7:0]     transfer_length_q;
	logic           ack_poll_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_address_q  <= '0;
			transfer_mode_q   <= MODE_WRITE;
			word_address_q    <= '0;
			transfer_length_q <= '0;
			ack_poll_enable_q <= 1'b1;
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				CFG_TARGET_ADDRESS:  target_address_q  <= wr_data[6:0];
				CFG_TRANSFER_MODE:   transfer_mode_q   <= transfer_mode_t'(wr_data[1:0]);
				CFG_WORD_ADDRESS:    word_address_q    <= wr_data;
				CFG_TRANSFER_LENGTH: transfer_length_q <= wr_data;
				CFG_ACK_POLL_ENABLE: ack_poll_enable_q <= wr_data[0];
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	// input register
	logic        valid_s1;
	operation_t  operation_s1;
	bus_status_t bus_status_s1;
	logic        ack_received_s1;
	logic [7:0]  received_byte_s1;
	logic [7:0]  write_data_s1;

	logic        out_valid_q;
	seq_result_t result_q;
	logic        advance;

	// s1 moves on whenever the result register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			operation_s1     <= operation_t'(operation);
			bus_status_s1    <= bus_status_t'(bus_status);
			ack_received_s1  <= ack_received;
			received_byte_s1 <= received_byte;
			write_data_s1    <= write_data;
		end
	end

	// step logic
	seq_state_t  state_q;
	seq_state_t  state_d;
	seq_result_t res;
	logic        count_below;
	logic [7:0]  count_next;

	assign count_below = state_q.byte_count < transfer_length_q;

	always_comb begin
		state_d    = state_q;
		res        = '0;
		count_next = state_q.byte_count;
		if (operation_s1 == OP_START) begin
			// start while busy is refused and changes nothing
			if (!state_q.busy) begin
				state_d.busy        = 1'b1;
				state_d.read_dir    = (transfer_mode_q == MODE_READ);
				state_d.waddr_pend  = (transfer_mode_q == MODE_WRITE_WADDR) ||
				                      (transfer_mode_q == MODE_RANDOM_READ);
				state_d.rand_read   = (transfer_mode_q == MODE_RANDOM_READ);
				state_d.rstart_pend = 1'b0;
				res.start_accepted  = 1'b1;
				res.drive_start     = 1'b1;
			end
		end else begin
			unique case (bus_status_s1)
				BUS_START_SENT: begin
					// address phase: slave address plus direction bit
					res.load_valid     = 1'b1;
					res.load_byte      = {target_address_q, state_q.read_dir};
					state_d.byte_count = '0;
				end
				BUS_BYTE_SENT: begin
					if (ack_received_s1) begin
						priority if (state_q.rstart_pend) begin
							res.drive_start     = 1'b1;
							state_d.rstart_pend = 1'b0;
						end else if (state_q.waddr_pend) begin
							state_d.waddr_pend = 1'b0;
							res.load_valid     = 1'b1;
							res.load_byte      = word_address_q;
							if (state_q.rand_read) begin
								state_d.rstart_pend = 1'b1;
								state_d.read_dir    = 1'b1;
							end
						end else if (!state_q.read_dir) begin
							if (count_below) begin
								res.load_valid     = 1'b1;
								res.load_byte      = write_data_s1;
								res.byte_index     = state_q.byte_count;
								state_d.byte_count = state_q.byte_count + 8'd1;
							end else begin
								res.drive_stop = 1'b1;
								state_d.busy   = 1'b0;
							end
						end else begin
							// ACK on the read address: wait for data
						end
					end else if (ack_poll_enable_q) begin
						// ack polling: retry from START, flags kept
						res.drive_start = 1'b1;
					end else begin
						res.failed   = 1'b1;
						state_d.busy = 1'b0;
					end
				end
				BUS_BYTE_RECEIVED: begin
					if (count_below) begin
						res.store_valid = 1'b1;
						res.read_data   = received_byte_s1;
						res.byte_index  = state_q.byte_count;
						res.ack_out     = 1'b1;
						count_next      = state_q.byte_count + 8'd1;
					end
					state_d.byte_count = count_next;
					// last byte (or zero length): NACK it and stop
					if (count_next == transfer_length_q) begin
						state_d.busy = 1'b0;
						res.ack_out  = 1'b0;
						res.drive_stop = 1'b1;
					end
				end
				BUS_OTHER: begin
					res.failed   = 1'b1;
					state_d.busy = 1'b0;
				end
			endcase
		end
		res.busy_res = state_d.busy;
	end

	// state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign start_accepted = result_q.start_accepted;
	assign drive_start    = result_q.drive_start;
	assign drive_stop     = result_q.drive_stop;
	assign load_valid     = result_q.load_valid;
	assign load_byte      = result_q.load_byte;
	assign ack_out        = result_q.ack_out;
	assign store_valid    = result_q.store_valid;
	assign read_data      = result_q.read_data;
	assign byte_index     = result_q.byte_index;
	assign busy_res       = result_q.busy_res;
	assign failed         = result_q.failed;

	// checks
	`SMBMS_ASSERT_IMPLY(a_stall_only_when_full, clk, arst_n, in_stall, out_valid && out_stall)
	`SMBMS_ASSERT_IMPLY(a_fail_releases_busy, clk, arst_n, out_valid && failed, !busy_res)
	`SMBMS_ASSERT_IMPLY(a_accept_drives_start, clk, arst_n, out_valid && start_accepted,
		drive_start && busy_res)
	`SMBMS_ASSERT_NEXT(a_advance_fills_output, clk, arst_n, advance, out_valid)

endmodule
